// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the tlv parser checker, clocked on clk and
// disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ATLV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atlv check failed");

// next-cycle implication
`define ATLV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atlv check failed");

`endif

// ===== rtl/atlv_pkg.sv =====
// ----------------------------------------------------------------------------
// atlv_pkg
// Types and codes shared by the tlv header parser modules
// ----------------------------------------------------------------------------
`default_nettype none

package atlv_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_CONTENT = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MORE     = 2'd1;
    localparam logic [1:0] ST_BAD_TAG  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // parser phases
    localparam logic [2:0] PH_IDENT     = 3'd0;
    localparam logic [2:0] PH_TAG       = 3'd1;
    localparam logic [2:0] PH_LEN_FIRST = 3'd2;
    localparam logic [2:0] PH_LEN_MORE  = 3'd3;
    localparam logic [2:0] PH_CONTENT   = 3'd4;

    localparam int FIELD_W  = 32;
    localparam int TDATA_W  = 88;
    localparam logic [3:0] HDR_MAX = 4'd15;

    typedef struct packed {
        logic [7:0] data;
        logic       eob;
    } atlv_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         tag_class;
        logic               is_constructed;
        logic [FIELD_W-1:0] tag_number;
        logic [FIELD_W-1:0] content_length;
        logic [3:0]         header_length;
        logic [7:0]         content_byte;
        logic               last_of_content;
        logic [1:0]         status;
    } atlv_rec_t;

endpackage

`default_nettype wire

// ===== rtl/asn1_tlv_header_parser.sv =====
// ----------------------------------------------------------------------------
// asn1_tlv_header_parser
// Streaming ber/der tlv header parser with content pass-through
// ----------------------------------------------------------------------------
// Bytes enter on the s_ stream, one per transfer; s_tlast marks the last
// byte of a buffer. For each tlv the m_ stream carries one header record
// (m_tuser kind header), then one transfer per content byte (kind content)
// with m_tlast on the final one; a header with empty content has m_tlast set.
// Errors come out as a kind error transfer carrying a status code: buffer
// ended mid-tlv, zero first long-tag byte, or tag/length/header overflow.
// After a tag or overflow error the rest of the buffer is dropped silently.
// An input transfer is held in the input register, then its result in the
// result register. Throughput is one byte per cycle while m_tready allows,
// set by the single decode stage between the two registers.
// Reset returns the parser to expect an identifier and empties both
// registers. When the receiver stalls, the result register holds and the
// input register still takes one more byte; s_tready then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module asn1_tlv_header_parser #(
    parameter int TAG_BITS    = 32,
    parameter int LENGTH_BITS = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [7:0]                   s_tdata,   // in_byte
    input  wire                          s_tlast,   // end_of_buffer
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // tag_class, is_constructed, tag_number, content_length, header_length,
    // content_byte, status, zero fill
    output logic [atlv_pkg::TDATA_W-1:0] m_tdata,
    output logic                         m_tlast,   // last_of_content
    output logic [1:0]                   m_tuser    // kind
);
    import atlv_pkg::*;

    logic       item_valid;
    atlv_item_t item;
    logic       pop;
    logic       res_valid;
    atlv_rec_t  res;

    // a byte moves on when the result register is free or draining
    assign pop = item_valid && (!m_tvalid || m_tready);

    atlv_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    atlv_parser #(
        .TAG_BITS    (TAG_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (pop),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    atlv_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (pop),
        .res_valid (res_valid),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/atlv_in_stage.sv =====
// ----------------------------------------------------------------------------
// atlv_in_stage
// Input register for the byte stream; releases one byte per pop
// ----------------------------------------------------------------------------
`default_nettype none

module atlv_in_stage (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [7:0]           s_tdata,
    input  wire                  s_tlast,
    input  wire                  pop,
    output logic                 item_valid,
    output atlv_pkg::atlv_item_t item
);
    import atlv_pkg::*;

    logic       valid_reg;
    atlv_item_t item_reg;

    assign s_tready   = !valid_reg || pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data <= s_tdata;
            item_reg.eob  <= s_tlast;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/atlv_parser.sv =====
// ----------------------------------------------------------------------------
// atlv_parser
// Tlv header state and the per-byte decode that yields at most one record
// ----------------------------------------------------------------------------
`default_nettype none

module atlv_parser #(
    parameter int TAG_BITS    = 32,
    parameter int LENGTH_BITS = 32
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  step,
    input  atlv_pkg::atlv_item_t item,
    output logic                 res_valid,
    output atlv_pkg::atlv_rec_t  res
);
    import atlv_pkg::*;

    logic [2:0]             phase_reg,  phase_next;
    logic [1:0]             class_reg,  class_next;
    logic                   cons_reg,   cons_next;
    logic [TAG_BITS-1:0]    tag_reg,    tag_next;
    logic [LENGTH_BITS-1:0] len_reg,    len_next;
    logic [6:0]             lol_reg,    lol_next;
    logic [3:0]             hcnt_reg,   hcnt_next;
    logic [LENGTH_BITS-1:0] cleft_reg,  cleft_next;
    logic                   skip_reg,   skip_next;

    logic       hdr_en;
    logic       fail_en;
    logic [1:0] fail_code;
    logic [7:0] b;
    logic       eob;
    logic [63:0] tag_wide;
    logic [63:0] len_wide;

    assign b        = item.data;
    assign eob      = item.eob;
    assign tag_wide = 64'(tag_next);
    assign len_wide = 64'(len_next);

    always_comb
    begin
        phase_next = phase_reg;
        class_next = class_reg;
        cons_next  = cons_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        lol_next   = lol_reg;
        hcnt_next  = hcnt_reg;
        cleft_next = cleft_reg;
        skip_next  = skip_reg;
        hdr_en     = 1'b0;
        fail_en    = 1'b0;
        fail_code  = ST_OK;
        res_valid  = 1'b0;
        res        = '0;

        if (step)
        begin
            if (skip_reg)
            begin
                if (eob)
                begin
                    skip_next  = 1'b0;
                    phase_next = PH_IDENT;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_TAG:
                    begin
                        if (hcnt_reg == 4'd1 && b[6:0] == 7'd0)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ST_BAD_TAG;
                        end
                        else if (tag_reg[TAG_BITS-1 -: 7] != 7'd0 || hcnt_reg == HDR_MAX)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ST_OVERFLOW;
                        end
                        else
                        begin
                            hcnt_next = hcnt_reg + 4'd1;
                            tag_next  = (tag_reg << 7) | TAG_BITS'(b[6:0]);
                            if (!b[7])
                            begin
                                phase_next = PH_LEN_FIRST;
                            end
                            if (eob)
                            begin
                                fail_en   = 1'b1;
                                fail_code = ST_MORE;
                            end
                        end
                    end
                    PH_LEN_FIRST:
                    begin
                        if (hcnt_reg == HDR_MAX)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ST_OVERFLOW;
                        end
                        else
                        begin
                            hcnt_next = hcnt_reg + 4'd1;
                            len_next  = '0;
                            if (b[7])
                            begin
                                lol_next = b[6:0];
                                // indefinite form reads as an empty content
                                if (b[6:0] == 7'd0)
                                begin
                                    hdr_en = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_LEN_MORE;
                                    if (eob)
                                    begin
                                        fail_en   = 1'b1;
                                        fail_code = ST_MORE;
                                    end
                                end
                            end
                            else
                            begin
                                len_next = LENGTH_BITS'(b[6:0]);
                                hdr_en   = 1'b1;
                            end
                        end
                    end
                    PH_LEN_MORE:
                    begin
                        if (len_reg[LENGTH_BITS-1 -: 8] != 8'd0 || hcnt_reg == HDR_MAX)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ST_OVERFLOW;
                        end
                        else
                        begin
                            hcnt_next = hcnt_reg + 4'd1;
                            len_next  = (len_reg << 8) | LENGTH_BITS'(b);
                            lol_next  = lol_reg - 7'd1;
                            if (lol_reg == 7'd1)
                            begin
                                hdr_en = 1'b1;
                            end
                            else if (eob)
                            begin
                                fail_en   = 1'b1;
                                fail_code = ST_MORE;
                            end
                        end
                    end
                    PH_CONTENT:
                    begin
                        cleft_next = cleft_reg - LENGTH_BITS'(1);
                        if (cleft_next != '0 && eob)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ST_MORE;
                        end
                        else
                        begin
                            res_valid           = 1'b1;
                            res.kind            = KIND_CONTENT;
                            res.content_byte    = b;
                            res.last_of_content = (cleft_next == '0);
                            if (cleft_next == '0)
                            begin
                                phase_next = PH_IDENT;
                            end
                        end
                    end
                    default:
                    begin
                        class_next = b[7:6];
                        cons_next  = b[5];
                        hcnt_next  = 4'd1;
                        len_next   = '0;
                        lol_next   = '0;
                        if (b[4:0] != 5'h1f)
                        begin
                            tag_next   = TAG_BITS'(b[4:0]);
                            phase_next = PH_LEN_FIRST;
                        end
                        else
                        begin
                            tag_next   = '0;
                            phase_next = PH_TAG;
                        end
                        if (eob)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ST_MORE;
                        end
                    end
                endcase
            end
        end

        if (hdr_en)
        begin
            if (len_next != '0 && eob)
            begin
                fail_en   = 1'b1;
                fail_code = ST_MORE;
            end
            else
            begin
                res_valid           = 1'b1;
                res.kind            = KIND_HEADER;
                res.tag_class       = class_next;
                res.is_constructed  = cons_next;
                res.tag_number      = tag_wide[FIELD_W-1:0];
                res.content_length  = len_wide[FIELD_W-1:0];
                res.header_length   = hcnt_next;
                res.last_of_content = (len_next == '0);
                cleft_next          = len_next;
                phase_next          = (len_next == '0) ? PH_IDENT : PH_CONTENT;
            end
        end

        if (fail_en)
        begin
            phase_next = PH_IDENT;
            // hard errors drop the rest of the buffer
            skip_next  = (fail_code != ST_MORE) && !eob;
            res_valid  = 1'b1;
            res        = '0;
            res.kind   = KIND_ERROR;
            res.status = fail_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDENT;
            class_reg <= '0;
            cons_reg  <= 1'b0;
            tag_reg   <= '0;
            len_reg   <= '0;
            lol_reg   <= '0;
            hcnt_reg  <= '0;
            cleft_reg <= '0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            cons_reg  <= cons_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            lol_reg   <= lol_next;
            hcnt_reg  <= hcnt_next;
            cleft_reg <= cleft_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/atlv_out_stage.sv =====
// ----------------------------------------------------------------------------
// atlv_out_stage
// Result register driving the master stream
// ----------------------------------------------------------------------------
`default_nettype none

module atlv_out_stage (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          load,
    input  wire                          res_valid,
    input  atlv_pkg::atlv_rec_t          res,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [atlv_pkg::TDATA_W-1:0] m_tdata,
    output logic                         m_tlast,
    output logic [1:0]                   m_tuser
);
    import atlv_pkg::*;

    logic      valid_reg;
    atlv_rec_t rec_reg;

    assign m_tvalid = valid_reg;
    assign m_tlast  = rec_reg.last_of_content;
    assign m_tuser  = rec_reg.kind;
    assign m_tdata  = {7'd0, rec_reg.status, rec_reg.content_byte, rec_reg.header_length,
                       rec_reg.content_length, rec_reg.tag_number,
                       rec_reg.is_constructed, rec_reg.tag_class};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            rec_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/atlv_checker.sv =====
// ----------------------------------------------------------------------------
// atlv_checker
// Port-level checks on the tlv parser result stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module atlv_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [atlv_pkg::TDATA_W-1:0]  m_tdata,
    input wire                          m_tlast,
    input wire [1:0]                    m_tuser
);
    import atlv_pkg::*;

    logic        is_hdr;
    logic        is_err;
    logic        is_data;
    logic [1:0]  status;
    logic [31:0] clen;
    logic        in_xfer;

    assign is_hdr  = m_tvalid && m_tuser == KIND_HEADER;
    assign is_err  = m_tvalid && m_tuser == KIND_ERROR;
    assign is_data = m_tvalid && m_tuser == KIND_CONTENT;
    assign status  = m_tdata[80:79];
    assign clen    = m_tdata[66:35];
    assign in_xfer = s_tvalid && s_tready;

    // stalled result holds
    `ATLV_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // errors carry a failure code, data records carry ok
    `ATLV_ASSERT_NOW(a_err_status, is_err, status != ST_OK && !m_tlast)
    `ATLV_ASSERT_NOW(a_data_status, is_hdr || is_data, status == ST_OK)
    // a header ends its tlv exactly when the content is empty
    `ATLV_ASSERT_NOW(a_hdr_last, is_hdr, m_tlast == (clen == 32'd0))
    // a byte passes through the input register before it reaches the result register
    `ATLV_ASSERT_NEXT(a_no_spurious, !m_tvalid && !in_xfer && !$past(in_xfer), !m_tvalid)

endmodule

bind asn1_tlv_header_parser atlv_checker u_atlv_checker (.*);

`default_nettype wire
